FILE: rtl/hit_count_cache_slot_policy_defines.svh
// assertion macros for the slot policy checker
`ifndef HIT_COUNT_CACHE_SLOT_POLICY_DEFINES_SVH
`define HIT_COUNT_CACHE_SLOT_POLICY_DEFINES_SVH

// same-cycle implication
`define HCCSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCCSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hccsp_pkg.sv
package hccsp_pkg;

  localparam int KEY_W    = 32;
  localparam int ACTIVE_W = 7;
  localparam int SLOT_W   = 6;
  localparam int TDATA_W  = 16;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic div_init;
    logic div_step;
    logic pass_init;
    logic evict;
    logic sweep;
    logic sweep_all;
    logic flush;
    logic install;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_hit;
    logic last_data;
    logic have_free;
    logic div_done;
    logic any_evicted;
    logic sweep_done;
  } dp_sts_t;

endpackage

FILE: rtl/hit_count_cache_slot_policy.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  name_hash
// m_axis    out  m_axis_tvalid/m_axis_tready  slot, was_hit, evicted_some, flushed_all
// cfg       in   cfg_wr_en_i                  active_entries
//
// a hit ends the scan at the matching entry; a miss with a free entry scans all n active entries
// a miss on a full table adds the divider (hit sum over n sets the eviction threshold) and a
// second pass that evicts, plus a flush sweep of the n active entries when none was evicted
// each pass reads one entry a cycle through the registered read port of the tables
// after reset a clearing pass over all ENTRIES entries runs before the first request is taken
// one request at a time; a finished result waits in the output register while the
// next request is accepted
module hit_count_cache_slot_policy #(
  parameter int ENTRIES  = 64,
  parameter int HIT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] name_hash
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] slot, [6] was_hit, [7] evicted_some,
                                      // [8] flushed_all, [15:9] zero
  input  logic        cfg_wr_en_i,
  input  logic [6:0]  cfg_wr_data_i   // active_entries
);
  import hccsp_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [SLOT_W-1:0] slot;
  logic              was_hit;
  logic              evicted;
  logic              flushed;

  hccsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hccsp_dp #(
    .ENTRIES  (ENTRIES),
    .HIT_BITS (HIT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_wr_en_i),
    .cfg_data_i (cfg_wr_data_i),
    .key_i      (s_axis_tdata),
    .slot_o     (slot),
    .was_hit_o  (was_hit),
    .evicted_o  (evicted),
    .flushed_o  (flushed)
  );

  assign m_axis_tdata = {7'd0, flushed, evicted, was_hit, slot};

endmodule

FILE: rtl/hccsp_ram.sv
module hccsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hccsp_ctrl.sv
module hccsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hccsp_pkg::dp_cmd_t cmd_o,
  input  hccsp_pkg::dp_sts_t sts_i
);
  import hccsp_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SCAN    = 8'b0000_0100,
    ST_DIV     = 8'b0000_1000,
    ST_EVICT   = 8'b0001_0000,
    ST_FLUSH   = 8'b0010_0000,
    ST_INSTALL = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep     = 1'b1;
        cmd_o.sweep_all = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_OUT;
        end else if (sts_i.last_data) begin
          if (sts_i.have_free) begin
            state_d = ST_INSTALL;
          end else begin
            cmd_o.div_init = 1'b1;
            state_d        = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.pass_init = 1'b1;
          state_d         = ST_EVICT;
        end
      end
      ST_EVICT: begin
        cmd_o.evict = 1'b1;
        if (sts_i.last_data) begin
          if (sts_i.any_evicted) begin
            state_d = ST_INSTALL;
          end else begin
            cmd_o.pass_init = 1'b1;
            state_d         = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        cmd_o.sweep = 1'b1;
        cmd_o.flush = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_INSTALL;
        end
      end
      ST_INSTALL: begin
        cmd_o.install = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/hccsp_dp.sv
module hccsp_dp #(
  parameter int ENTRIES  = 64,
  parameter int HIT_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hccsp_pkg::dp_cmd_t                 cmd_i,
  output hccsp_pkg::dp_sts_t                 sts_o,
  input  logic                               cfg_we_i,
  input  logic [hccsp_pkg::ACTIVE_W-1:0]     cfg_data_i,
  input  logic [hccsp_pkg::KEY_W-1:0]        key_i,
  output logic [hccsp_pkg::SLOT_W-1:0]       slot_o,
  output logic                               was_hit_o,
  output logic                               evicted_o,
  output logic                               flushed_o
);
  import hccsp_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int SUM_W = HIT_BITS + $clog2(ENTRIES);
  localparam int DC_W  = $clog2(SUM_W);
  localparam logic [HIT_BITS-1:0] HIT_MAX = {HIT_BITS{1'b1}};

  logic [ACTIVE_W-1:0] act_q;
  logic [KEY_W-1:0]    key_q;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                p_vld_q;
  logic [IDX_W-1:0]    p_addr_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [DC_W-1:0]     dcnt_q, dcnt_d;
  logic                have_free_q, have_free_d;
  logic [IDX_W-1:0]    free_q, free_d;
  logic                hit_q, hit_d;
  logic                ev_q, ev_d;
  logic                fl_q, fl_d;
  logic [SLOT_W-1:0]   slot_q;
  logic                was_hit_q, evicted_q, flushed_q;

  logic [CNT_W-1:0]    n_w, limit_w;
  logic                issue;
  logic [KEY_W-1:0]    key_rd;
  logic [HIT_BITS-1:0] hits_rd, hits_inc, thr;
  logic                data_hit, data_free, evict_hit;
  logic                hits_we;
  logic [IDX_W-1:0]    hits_waddr;
  logic [HIT_BITS-1:0] hits_wdata;
  logic [CNT_W:0]      div_t, div_diff;
  logic                div_ge;

  // active size, clamped to one and to the table depth
  always_comb begin
    if (32'(act_q) > ENTRIES) begin
      n_w = CNT_W'(ENTRIES);
    end else if (act_q == '0) begin
      n_w = CNT_W'(1);
    end else begin
      n_w = CNT_W'(act_q);
    end
  end

  assign limit_w = cmd_i.sweep_all ? CNT_W'(ENTRIES) : n_w;
  assign issue   = (cmd_i.scan || cmd_i.evict) && (idx_q < n_w);

  hccsp_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.install),
    .waddr_i (free_q),
    .wdata_i (key_q),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (key_rd)
  );

  hccsp_ram #(.WIDTH(HIT_BITS), .DEPTH(ENTRIES)) u_hits_ram (
    .clk_i   (clk_i),
    .we_i    (hits_we),
    .waddr_i (hits_waddr),
    .wdata_i (hits_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (hits_rd)
  );

  assign hits_inc  = (hits_rd == HIT_MAX) ? hits_rd : hits_rd + HIT_BITS'(1);
  assign thr       = sum_q[HIT_BITS:1];
  assign data_hit  = p_vld_q && (hits_rd != '0) && (key_rd == key_q);
  assign data_free = p_vld_q && (hits_rd == '0);
  assign evict_hit = p_vld_q && (hits_rd <= thr);

  always_comb begin
    hits_we    = 1'b0;
    hits_waddr = p_addr_q;
    hits_wdata = '0;
    if (cmd_i.sweep) begin
      hits_we    = 1'b1;
      hits_waddr = idx_q[IDX_W-1:0];
    end else if (cmd_i.scan && data_hit) begin
      hits_we    = 1'b1;
      hits_wdata = hits_inc;
    end else if (cmd_i.evict && evict_hit) begin
      hits_we    = 1'b1;
    end else if (cmd_i.install) begin
      hits_we    = 1'b1;
      hits_waddr = free_q;
      hits_wdata = HIT_BITS'(1);
    end
  end

  // one quotient bit a cycle, the running sum shifts into the quotient
  assign div_t    = {rem_q, sum_q[SUM_W-1]};
  assign div_diff = div_t - {1'b0, n_w};
  assign div_ge   = div_t >= {1'b0, n_w};

  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    have_free_d = have_free_q;
    free_d      = free_q;
    hit_d       = hit_q;
    ev_d        = ev_q;
    fl_d        = fl_q;

    if (cmd_i.sweep) begin
      idx_d = sts_o.sweep_done ? '0 : idx_q + CNT_W'(1);
    end else if (issue) begin
      idx_d = idx_q + CNT_W'(1);
    end

    if (cmd_i.scan) begin
      if (data_hit) begin
        hit_d  = 1'b1;
        free_d = p_addr_q;
      end else if (p_vld_q) begin
        sum_d = sum_q + SUM_W'(hits_rd);
        if (data_free) begin
          have_free_d = 1'b1;
          free_d      = p_addr_q;
        end
      end
    end

    if (cmd_i.div_init) begin
      rem_d  = '0;
      dcnt_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d  = div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
      sum_d  = {sum_q[SUM_W-2:0], div_ge};
      dcnt_d = dcnt_q + DC_W'(1);
    end

    if (cmd_i.evict && evict_hit) begin
      ev_d   = 1'b1;
      free_d = p_addr_q;
    end

    if (cmd_i.sweep && cmd_i.flush) begin
      fl_d   = 1'b1;
      free_d = '0;
    end

    if (cmd_i.load || cmd_i.pass_init) begin
      idx_d = '0;
    end

    if (cmd_i.load) begin
      sum_d       = '0;
      have_free_d = 1'b0;
      hit_d       = 1'b0;
      ev_d        = 1'b0;
      fl_d        = 1'b0;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.scan_hit    = data_hit;
    sts_o.last_data   = p_vld_q && (CNT_W'(p_addr_q) == n_w - CNT_W'(1));
    sts_o.have_free   = have_free_q || (cmd_i.scan && !data_hit && data_free);
    sts_o.div_done    = dcnt_q == DC_W'(SUM_W - 1);
    sts_o.any_evicted = ev_q || (cmd_i.evict && evict_hit);
    sts_o.sweep_done  = idx_q == limit_w - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= ACTIVE_RST;
      idx_q       <= '0;
      p_vld_q     <= 1'b0;
      dcnt_q      <= '0;
      have_free_q <= 1'b0;
      hit_q       <= 1'b0;
      ev_q        <= 1'b0;
      fl_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        act_q <= cfg_data_i;
      end
      idx_q       <= idx_d;
      p_vld_q     <= issue && !cmd_i.load && !cmd_i.pass_init;
      dcnt_q      <= dcnt_d;
      have_free_q <= have_free_d;
      hit_q       <= hit_d;
      ev_q        <= ev_d;
      fl_q        <= fl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
    end
    p_addr_q <= idx_q[IDX_W-1:0];
    sum_q    <= sum_d;
    rem_q    <= rem_d;
    free_q   <= free_d;
    if (cmd_i.out_load) begin
      slot_q    <= SLOT_W'(free_q);
      was_hit_q <= hit_q;
      evicted_q <= ev_q;
      flushed_q <= fl_q;
    end
  end

  assign slot_o    = slot_q;
  assign was_hit_o = was_hit_q;
  assign evicted_o = evicted_q;
  assign flushed_o = flushed_q;

endmodule

FILE: rtl/hccsp_checker.sv
`include "hit_count_cache_slot_policy_defines.svh"

module hccsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `HCCSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `HCCSP_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
  `HCCSP_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0, "nonzero padding")
  `HCCSP_ASSERT_IMPL(a_hit_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[6], !m_axis_tdata[7] && !m_axis_tdata[8], "hit with eviction flags")
  `HCCSP_ASSERT_IMPL(a_evict_or_flush, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[7] && m_axis_tdata[8]), "evict and flush together")

endmodule

bind hit_count_cache_slot_policy hccsp_checker u_hccsp_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import hccsp_pkg::*;

  localparam int          ENTRIES      = 64;
  localparam logic [15:0] HIT_MAX      = 16'hFFFF;
  localparam int          RANDOM_ITEMS = 1550;
  localparam int          HAMMER_ITEMS = 24;
  localparam longint      CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              was_hit;
    logic              evicted_some;
    logic              flushed_all;
  } slot_result_t;

  typedef struct packed {
    logic         typed;
    slot_result_t want;
  } lookup_tag_t;

  typedef enum logic [1:0] {ROW_KEY, ROW_KEY_CHECKED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [KEY_W-1:0] value;
    slot_result_t     want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [KEY_W-1:0]   s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               cfg_wr_en_i;
  logic [ACTIVE_W-1:0] cfg_wr_data_i;

  logic [KEY_W-1:0]    model_key  [ENTRIES];
  logic [15:0]         model_hits [ENTRIES];
  logic [ACTIVE_W-1:0] model_active;

  lookup_tag_t  lookup_tags[$];
  slot_result_t pending_lookups[$];

  int unsigned mismatches  = 0;
  longint      cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          quiet       = 1'b0;
  int unsigned stall_tick  = 0;
  rx_mode_e    stall_mode  = RX_OPEN;

  int size_plan [12] = '{1, 2, 3, 7, 16, 31, 64, 0, 127, 100, 48, 64};

  stim_row_t directed_rows [20] = '{
    '{ROW_KEY_CHECKED, 32'h0000_0000, '{6'd63, 1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h0000_0000, '{6'd63, 1'b1, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'hFFFF_FFFF, '{6'd62, 1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'hFFFF_FFFF, '{6'd62, 1'b1, 1'b0, 1'b0}},
    '{ROW_CFG,         32'd0,         '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h8000_0000, '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h1234_5678, '{6'd0,  1'b0, 1'b0, 1'b1}},
    '{ROW_KEY_CHECKED, 32'h1234_5678, '{6'd0,  1'b1, 1'b0, 1'b0}},
    '{ROW_CFG,         32'd2,         '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'hFFFF_FFFF, '{6'd1,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h1234_5678, '{6'd0,  1'b1, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h1234_5678, '{6'd0,  1'b1, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h0000_0005, '{6'd1,  1'b0, 1'b1, 1'b0}},
    '{ROW_CFG,         32'd127,       '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h0000_0000, '{6'd63, 1'b1, 1'b0, 1'b0}},
    '{ROW_KEY_CHECKED, 32'h0000_0001, '{6'd61, 1'b0, 1'b0, 1'b0}},
    '{ROW_CFG,         32'd64,        '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY,         32'hAAAA_AAAA, '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY,         32'h5555_5555, '{6'd0,  1'b0, 1'b0, 1'b0}},
    '{ROW_KEY,         32'h0000_0005, '{6'd0,  1'b0, 1'b0, 1'b0}}
  };

  hit_count_cache_slot_policy #(
    .ENTRIES (ENTRIES),
    .HIT_BITS(16)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int clamp_active(input int value);
    if (value < 1) return 1;
    if (value > ENTRIES) return ENTRIES;
    return value;
  endfunction

  function automatic slot_result_t predict_lookup(input logic [KEY_W-1:0] key);
    int              n;
    longint unsigned total;
    longint unsigned thresh;
    bit              have_free;
    int              free_idx;
    slot_result_t    res;
    n         = clamp_active(int'(model_active));
    total     = 0;
    have_free = 1'b0;
    free_idx  = 0;
    res       = '0;
    for (int i = 0; i < n; i++) begin
      if (model_hits[i] != 0 && model_key[i] == key) begin
        if (model_hits[i] != HIT_MAX) model_hits[i] = model_hits[i] + 1'b1;
        res.slot    = i[SLOT_W-1:0];
        res.was_hit = 1'b1;
        return res;
      end
      if (model_hits[i] == 0) begin
        have_free = 1'b1;
        free_idx  = i;
      end
      total += model_hits[i];
    end
    if (!have_free) begin
      thresh = total / n / 2;
      for (int i = 0; i < n; i++) begin
        if (model_hits[i] <= thresh) begin
          model_key[i]     = '0;
          model_hits[i]    = '0;
          have_free        = 1'b1;
          res.evicted_some = 1'b1;
          free_idx         = i;
        end
      end
      if (!have_free) begin
        for (int i = 0; i < n; i++) begin
          model_key[i]  = '0;
          model_hits[i] = '0;
        end
        res.flushed_all = 1'b1;
        free_idx        = 0;
      end
    end
    model_key[free_idx]  = key;
    model_hits[free_idx] = 16'd1;
    res.slot             = free_idx[SLOT_W-1:0];
    return res;
  endfunction

  // sender side, called at a rising edge
  task automatic send_key(input logic [KEY_W-1:0] key, input bit typed,
                          input slot_result_t want);
    lookup_tags.push_back('{typed, want});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 24);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_lookups();
    s_axis_tvalid <= 1'b0;
    while (lookup_tags.size() != 0 || pending_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_active(input logic [ACTIVE_W-1:0] value);
    drain_lookups();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 0) stall_mode <= rx_mode_e'($urandom_range(0, 3));
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      case (stall_mode)
        RX_OPEN:    m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_axis_tready <= (stall_tick % 5 < 2);
        default:    m_axis_tready <= (stall_tick % 23 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    slot_result_t got;
    slot_result_t want;
    slot_result_t predicted;
    lookup_tag_t  tag;
    if (!rst_ni) begin
      model_active = ACTIVE_RST;
      foreach (model_key[i]) begin
        model_key[i]  = '0;
        model_hits[i] = '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.slot         = m_axis_tdata[5:0];
        got.was_hit      = m_axis_tdata[6];
        got.evicted_some = m_axis_tdata[7];
        got.flushed_all  = m_axis_tdata[8];
        if (pending_lookups.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: result with no request outstanding, slot %0d", cycle_count,
                     got.slot);
        end else begin
          want = pending_lookups.pop_front();
          if (got.slot != want.slot || got.was_hit != want.was_hit ||
              got.evicted_some != want.evicted_some || got.flushed_all != want.flushed_all) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"cycle %0d: expected slot %0d hit %0b evict %0b flush %0b, ",
                        "got slot %0d hit %0b evict %0b flush %0b"},
                       cycle_count, want.slot, want.was_hit, want.evicted_some,
                       want.flushed_all, got.slot, got.was_hit, got.evicted_some,
                       got.flushed_all);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tag       = (lookup_tags.size() != 0) ? lookup_tags.pop_front() : '0;
        predicted = predict_lookup(s_axis_tdata);
        pending_lookups.push_back(tag.typed ? tag.want : predicted);
      end
      if (cfg_wr_en_i) model_active = cfg_wr_data_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] key_pool[$];
    int               sent;
    int               phase;
    int               size_sel;
    int               eff;
    int               pick;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (ENTRIES + 8) @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        set_active(directed_rows[r].value[ACTIVE_W-1:0]);
      else
        send_key(directed_rows[r].value, directed_rows[r].kind == ROW_KEY_CHECKED,
                 directed_rows[r].want);
    end

    // one key hammered on a single entry, then a new key flushes it
    set_active(7'd1);
    quiet = 1'b1;
    repeat (HAMMER_ITEMS) send_key(32'hDEAD_BEEF, 1'b0, '0);
    send_key(32'hDEAD_BEEE, 1'b0, '0);
    quiet = 1'b0;

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      size_sel = (phase < 12) ? size_plan[phase] : int'($urandom_range(0, 127));
      set_active(size_sel[ACTIVE_W-1:0]);
      eff = clamp_active(size_sel);
      key_pool.delete();
      repeat (eff + $urandom_range(1, eff + 2)) key_pool.push_back($urandom);
      repeat (110 + $urandom_range(0, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          key = $urandom;
        else if (pick < 12)
          key = pick[0] ? '1 : '0;
        else if (pick < 50)
          key = key_pool[$urandom_range(0, (key_pool.size() - 1) / 4)];
        else
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        send_key(key, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain_lookups();
    repeat (240) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: hit_count_cache_slot_policy.f
+incdir+rtl
rtl/hccsp_pkg.sv
rtl/hccsp_ram.sv
rtl/hccsp_ctrl.sv
rtl/hccsp_dp.sv
rtl/hit_count_cache_slot_policy.sv
rtl/hccsp_checker.sv
tb/sv/tb.sv
